// ===== rtl/srr_pkg.sv =====
// shared types and constants for the stereo interpolating resampler
// no dependencies; imported by srr_lane, srr_merge and the top level

package srr_pkg;

	typedef enum logic [1:0] {
		MODE_NEAREST = 2'd0,
		MODE_LINEAR  = 2'd1,
		MODE_CUBIC   = 2'd2,
		MODE_LIN_ALT = 2'd3
	} mode_t;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_STEP = 2'd1;
	localparam logic [1:0] REG_PASS = 2'd2;

	localparam int WIN_FRAMES = 4;
	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 20;
	localparam int CFG_W      = 20;
	// interpolation numerators are normalized to this many fraction bits
	localparam int NUM_D      = 33;
	localparam int LIM_SH     = NUM_D + 15;
	localparam int ACC_W      = 56;
	localparam int DIV_SH     = 16;
	localparam int SPLIT_SH   = 18;
	localparam int COEF_W     = 20;
	localparam logic [14:0] PCM_MAX = 15'd32767;

	typedef enum logic [3:0] {
		LS_IDLE,
		LS_PREP,
		LS_M1,
		LS_A1,
		LS_M2,
		LS_M3,
		LS_A3,
		LS_DIV,
		LS_M4,
		LS_M5,
		LS_A5,
		LS_CLAMP,
		LS_SCALE,
		LS_DONE
	} lane_st_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_PASS,
		TS_CHECK,
		TS_RUN
	} top_st_t;

	typedef struct packed {
		logic  start;
		mode_t mode;
	} lane_ctl_t;

endpackage

// ===== rtl/stereo_interpolating_resampler.sv =====
// stereo interpolating resampler, top level: frame window, read position,
// output sequencer, two srr_lane channels and the srr_merge output stage
//
// usage
//   s_tdata carries one stereo frame (left low, right high). cfg_we with
//   cfg_index/cfg_data sets mode, step_q16 and pass_through; write only idle.
//   with pass_through set each frame comes back unchanged as one word with
//   m_tlast high. otherwise each frame yields zero or more output words, the
//   final one of the burst marked by m_tlast.
// output sequencing
//   per output word the sequencer passes through its check state and then
//   waits in its run state for the lane run in nearest, linear or cubic mode.
//   both channels run in lockstep, each on its own single multiplier. a frame
//   yields at most MAX_OUTPUTS_PER_FRAME output words (64 by default).
//   a lane result goes to the holding register when the lane run ends and
//   the next check loads it toward m_tvalid; s_tready is high only between frames.
// reset and stall
//   arst_n clears the window count, read position, output valid and restores
//   mode linear, step 1.0 and pass_through on. a stalled m_tready holds the
//   output word; the next result waits in a holding register and the
//   sequencer pauses until the output register frees up.

module stereo_interpolating_resampler #(
	parameter int FRAC_BITS = 16,
	parameter int MAX_OUTPUTS_PER_FRAME = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // left_in, right_in
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // left_out, right_out
	output logic                       m_tlast,   // last
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [srr_pkg::CFG_W-1:0]  cfg_data
);
	import srr_pkg::*;

	localparam int POS_BITS = FRAC_BITS + 8;
	localparam int FR_DOWN = FRAC_BITS > 16 ? FRAC_BITS - 16 : 0;
	localparam int FR_UP = FRAC_BITS < 16 ? 16 - FRAC_BITS : 0;
	localparam int SW = STEP_W + FR_DOWN;
	localparam int UEW = FRAC_BITS + 16;
	localparam int CW = $clog2(MAX_OUTPUTS_PER_FRAME + 1);
	localparam logic [POS_BITS-1:0] ONE = POS_BITS'(1) << FRAC_BITS;
	localparam logic [POS_BITS:0] HALF = (POS_BITS + 1)'(1) << (FRAC_BITS - 1);

	function automatic logic [1:0] idx_clamp(input logic [8:0] x);
		return (x > 9'd3) ? 2'd3 : x[1:0];
	endfunction

	// config
	mode_t mode_q;
	logic [STEP_W-1:0] step_q;
	logic pass_q;

	// state
	top_st_t state_q, state_d;
	logic [WIN_FRAMES-1:0][31:0] win_q;
	logic [2:0] seen_q;
	logic [POS_BITS-1:0] pos_q;
	logic [CW-1:0] count_q;
	logic pend_v_q;
	logic [SAMPLE_W-1:0] pend_l_q, pend_r_q;

	logic s_acc;
	logic lane_start, out_load, out_last, out_pass, pend_push;
	logic free;
	logic ready_w;
	logic [SW-1:0] step_ext;
	logic [POS_BITS-1:0] step_w;
	logic [7:0] base_w;
	logic [FRAC_BITS-1:0] frac_w;
	logic [UEW-1:0] u_ext;
	logic [15:0] u_w;
	logic [8:0] need_w, nsum_top, seen_m1, nidx9, b9;
	logic [POS_BITS:0] nsum;
	logic [1:0] i0, i1, i2, i3;
	logic [31:0] newest;
	logic [SAMPLE_W-1:0] out_l, out_r;
	lane_ctl_t lane_ctl;
	logic [1:0] lane_done;
	logic [1:0][15:0] lane_res;

	assign s_acc = s_tvalid && s_tready;

	assign step_ext = (SW'(step_q) << FR_DOWN) >> FR_UP;
	assign step_w   = POS_BITS'(step_ext);
	assign base_w   = pos_q[POS_BITS-1:FRAC_BITS];
	assign frac_w   = pos_q[FRAC_BITS-1:0];
	assign u_ext    = UEW'(frac_w) << FR_UP;
	assign u_w      = u_ext[FR_DOWN +: 16];

	assign need_w  = (mode_q == MODE_CUBIC) ? 9'd3 : 9'd2;
	assign ready_w = ({1'b0, base_w} + need_w <= 9'(seen_q))
		&& (count_q < CW'(MAX_OUTPUTS_PER_FRAME));

	// tap indices
	assign nsum     = {1'b0, pos_q} + HALF;
	assign nsum_top = nsum[POS_BITS:FRAC_BITS];
	assign seen_m1  = 9'(seen_q) - 9'd1;
	assign nidx9    = (nsum_top > seen_m1) ? seen_m1 : nsum_top;
	assign b9       = {1'b0, base_w};
	assign i0 = idx_clamp((b9 == 9'd0) ? 9'd0 : b9 - 9'd1);
	assign i1 = idx_clamp((mode_q == MODE_NEAREST) ? nidx9 : b9);
	assign i2 = idx_clamp(b9 + 9'd1);
	assign i3 = idx_clamp(b9 + 9'd2);

	assign newest = win_q[2'(seen_q - 3'd1)];

	assign lane_ctl.start = lane_start;
	assign lane_ctl.mode  = mode_q;

	for (genvar c = 0; c < 2; c++) begin : g_lane
		logic [3:0][15:0] taps;
		assign taps[0] = win_q[i0][16*c +: 16];
		assign taps[1] = win_q[i1][16*c +: 16];
		assign taps[2] = win_q[i2][16*c +: 16];
		assign taps[3] = win_q[i3][16*c +: 16];

		srr_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.frac   (frac_w),
			.u      (u_w),
			.taps   (taps),
			.done   (lane_done[c]),
			.result (lane_res[c])
		);
	end

	assign out_l = out_pass ? newest[15:0] : pend_l_q;
	assign out_r = out_pass ? newest[31:16] : pend_r_q;

	srr_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.left     (out_l),
		.right    (out_r),
		.last     (out_last),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			step_q <= STEP_W'(65536);
			pass_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data[1:0]);
				REG_STEP: step_q <= cfg_data[STEP_W-1:0];
				REG_PASS: pass_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		lane_start = 1'b0;
		out_load   = 1'b0;
		out_last   = 1'b1;
		out_pass   = 1'b0;
		pend_push  = 1'b0;
		case (state_q)
			TS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pass_q ? TS_PASS : TS_CHECK;
				end
			end
			TS_PASS: begin
				out_pass = 1'b1;
				if (free) begin
					out_load = 1'b1;
					state_d  = TS_IDLE;
				end
			end
			TS_CHECK: begin
				if (!pend_v_q || free) begin
					pend_push = pend_v_q;
					out_load  = pend_v_q;
					out_last  = !ready_w;
					if (ready_w) begin
						lane_start = 1'b1;
						state_d    = TS_RUN;
					end else begin
						state_d = TS_IDLE;
					end
				end
			end
			TS_RUN: begin
				if (&lane_done) begin
					state_d = TS_CHECK;
				end
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	// window count, read position, output count, holding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			pos_q    <= '0;
			count_q  <= '0;
			pend_v_q <= 1'b0;
		end else if (s_acc) begin
			count_q  <= '0;
			pend_v_q <= 1'b0;
			if (seen_q == 3'(WIN_FRAMES)) begin
				pos_q <= (pos_q >= ONE) ? pos_q - ONE : '0;
			end else begin
				seen_q <= seen_q + 3'd1;
			end
		end else if (state_q == TS_RUN && (&lane_done)) begin
			pend_v_q <= 1'b1;
			count_q  <= count_q + CW'(1);
			pos_q    <= pos_q + step_w;
		end else if (pend_push) begin
			pend_v_q <= 1'b0;
		end
	end

	// frame window and holding word
	always_ff @(posedge clk) begin
		if (s_acc) begin
			if (seen_q == 3'(WIN_FRAMES)) begin
				win_q <= {s_tdata, win_q[WIN_FRAMES-1:1]};
			end else begin
				win_q[seen_q[1:0]] <= s_tdata;
			end
		end
		if (state_q == TS_RUN && (&lane_done)) begin
			pend_l_q <= lane_res[0];
			pend_r_q <= lane_res[1];
		end
	end

endmodule

// ===== rtl/srr_lane.sv =====
// one channel interpolator: nearest, linear or cubic over four taps
// sequenced around a single multiplier; uses srr_pkg

module srr_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srr_pkg::lane_ctl_t    ctl,
	input  logic [FRAC_BITS-1:0]  frac,
	input  logic [15:0]           u,
	input  logic [3:0][15:0]      taps,
	output logic                  done,
	output logic signed [15:0]    result
);
	import srr_pkg::*;

	localparam int MBW = (FRAC_BITS > 16 ? FRAC_BITS : 16) + 1;
	localparam int PW = COEF_W + MBW;
	localparam int LIN_SH = NUM_D - FRAC_BITS;
	localparam int SC_W = LIM_SH + 15;
	localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(1) << LIM_SH;
	localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;
	localparam logic signed [ACC_W-1:0] DIV_BIAS = (ACC_W'(1) << DIV_SH) - ACC_W'(1);

	lane_st_t state_q, state_d;

	logic signed [15:0] p0, p1, p2, p3;
	logic signed [COEF_W-1:0] e0, e1, e2, e3;
	logic signed [COEF_W-1:0] a0_q, a1_q, a2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PW-1:0] prod_q;
	logic signed [COEF_W-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [MBW-1:0] u_op, frac_op;
	logic signed [COEF_W-1:0] hi_op, lo_op;
	logic signed [ACC_W-1:0] abs_w, bias_w, div_w;
	logic [LIM_SH-1:0] mag_q;
	logic neg_q, sat_q;
	logic [14:0] res_q;
	logic [SC_W-1:0] sc_w;
	logic signed [15:0] res16;
	logic is_cubic, is_near;

	assign p0 = taps[0];
	assign p1 = taps[1];
	assign p2 = taps[2];
	assign p3 = taps[3];
	assign e0 = COEF_W'(p0);
	assign e1 = COEF_W'(p1);
	assign e2 = COEF_W'(p2);
	assign e3 = COEF_W'(p3);

	assign is_cubic = (ctl.mode == MODE_CUBIC);
	assign is_near  = (ctl.mode == MODE_NEAREST);

	assign u_op    = MBW'(u);
	assign frac_op = MBW'(frac);
	assign hi_op   = acc_q[SPLIT_SH+COEF_W-1:SPLIT_SH];
	assign lo_op   = {2'b00, acc_q[SPLIT_SH-1:0]};

	assign abs_w  = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign bias_w = acc_q[ACC_W-1] ? DIV_BIAS : '0;
	assign div_w  = (acc_q + bias_w) >>> DIV_SH;
	assign sc_w   = {mag_q, 15'b0} - SC_W'(mag_q);

	assign res16  = {1'b0, res_q};
	assign result = neg_q ? -res16 : res16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		mul_a   = hi_op;
		mul_b   = u_op;
		case (state_q)
			LS_IDLE: begin
				if (ctl.start) begin
					state_d = LS_PREP;
				end
			end
			LS_PREP: begin
				state_d = is_near ? LS_CLAMP : LS_M1;
			end
			LS_M1: begin
				mul_a   = is_cubic ? a0_q : a2_q;
				mul_b   = is_cubic ? u_op : frac_op;
				state_d = LS_A1;
			end
			LS_A1: begin
				state_d = is_cubic ? LS_M2 : LS_CLAMP;
			end
			LS_M2: begin
				state_d = LS_M3;
			end
			LS_M3: begin
				mul_a   = lo_op;
				state_d = LS_A3;
			end
			LS_A3: begin
				state_d = LS_DIV;
			end
			LS_DIV: begin
				state_d = LS_M4;
			end
			LS_M4: begin
				state_d = LS_M5;
			end
			LS_M5: begin
				mul_a   = lo_op;
				state_d = LS_A5;
			end
			LS_A5: begin
				state_d = LS_CLAMP;
			end
			LS_CLAMP: begin
				state_d = LS_SCALE;
			end
			LS_SCALE: begin
				state_d = LS_DONE;
			end
			LS_DONE: begin
				done    = 1'b1;
				state_d = LS_IDLE;
			end
			default: begin
				state_d = LS_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			LS_PREP: begin
				a0_q <= (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
				a1_q <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
				a2_q <= is_cubic ? (e2 - e0) : (e2 - e1);
				if (is_near) begin
					acc_q <= ACC_W'(p1) <<< NUM_D;
				end
			end
			LS_M1, LS_M2, LS_M4: begin
				prod_q <= mul_a * mul_b;
			end
			LS_A1: begin
				if (is_cubic) begin
					acc_q <= ACC_W'(prod_q) + (ACC_W'(a1_q) <<< DIV_SH);
				end else begin
					acc_q <= (ACC_W'(p1) <<< NUM_D) + (ACC_W'(prod_q) <<< LIN_SH);
				end
			end
			LS_M3: begin
				prod_q <= mul_a * mul_b;
				acc_q  <= (ACC_W'(prod_q) <<< SPLIT_SH) + (ACC_W'(a2_q) <<< 32);
			end
			LS_A3, LS_A5: begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
			LS_DIV: begin
				acc_q <= div_w;
			end
			LS_M5: begin
				prod_q <= mul_a * mul_b;
				acc_q  <= (ACC_W'(prod_q) <<< SPLIT_SH) + (ACC_W'(p1) <<< NUM_D);
			end
			LS_CLAMP: begin
				neg_q <= acc_q[ACC_W-1];
				sat_q <= (acc_q >= LIM_POS) || (acc_q <= LIM_NEG);
				mag_q <= abs_w[LIM_SH-1:0];
			end
			LS_SCALE: begin
				res_q <= sat_q ? PCM_MAX : sc_w[SC_W-1:LIM_SH];
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/srr_merge.sv =====
// output stage: merges the lane results or pass-through frame and the last flag
// into one word register between the sequencer and the master side; uses srr_pkg

module srr_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [srr_pkg::SAMPLE_W-1:0] left,
	input  logic [srr_pkg::SAMPLE_W-1:0] right,
	input  logic                         last,
	output logic                         free,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,   // left_out, right_out
	output logic                         m_tlast    // last
);
	import srr_pkg::*;

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {right, left};
			m_tlast <= last;
		end
	end

endmodule
